### rtl/core/ppmp6_pkg.sv
// shared types, character codes and defaults for the p6 sprite parser
package ppmp6_pkg;

  // default image geometry
  localparam int unsigned ImageWidthDef  = 16;
  localparam int unsigned ImageHeightDef = 16;

  // header characters
  localparam logic [7:0] ChP     = 8'h50;
  localparam logic [7:0] ChSix   = 8'h36;
  localparam logic [7:0] ChHash  = 8'h23;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;

  localparam logic [15:0] MaxVal = 16'd255;

  // result queue geometry
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = 2;
  localparam int unsigned FifoCntW  = 3;

  typedef enum logic [3:0] {
    PH_MAGIC_P = 4'd0,
    PH_MAGIC_6 = 4'd1,
    PH_WS_W    = 4'd2,
    PH_NUM_W   = 4'd3,
    PH_WS_H    = 4'd4,
    PH_NUM_H   = 4'd5,
    PH_WS_M    = 4'd6,
    PH_NUM_M   = 4'd7,
    PH_PAYLOAD = 4'd8,
    PH_DONE    = 4'd9
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_MAGIC  = 2'd1,
    ST_HEADER = 2'd2,
    ST_SHORT  = 2'd3
  } status_e;

  typedef enum logic {
    KIND_PIXEL  = 1'b0,
    KIND_STATUS = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  pixel_index;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    status_e     status;
    logic        run_end;
  } res_t;

endpackage

### rtl/core/ppmp6_parser.sv
// header state machine and pixel grouping, one byte per cycle while fire_i is high
module ppmp6_parser import ppmp6_pkg::*; #(
  parameter int unsigned IMAGE_WIDTH  = ImageWidthDef,
  parameter int unsigned IMAGE_HEIGHT = ImageHeightDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  logic [7:0] byte_i,
  input  logic       eof_i,
  output logic [1:0] push_cnt_o,
  output res_t       res_a_o,
  output res_t       res_b_o
);

  localparam int unsigned PixTotal = IMAGE_WIDTH * IMAGE_HEIGHT;
  localparam int unsigned PixW     = $clog2(PixTotal + 1);
  localparam logic [PixW-1:0] PixLast = PixW'(PixTotal - 1);

  phase_e          phase_q, phase_d;
  logic            in_comment_q, in_comment_d;
  logic [15:0]     acc_q, acc_d;
  logic [15:0]     wid_q, wid_d;
  logic [15:0]     hei_q, hei_d;
  logic [1:0]      slot_q, slot_d;
  logic [PixW-1:0] pix_q, pix_d;
  logic [7:0]      red_q, red_d;
  logic [7:0]      grn_q, grn_d;

  logic            emit_pix, emit_st;
  status_e         st_code;
  logic            is_digit, is_blank;
  logic [3:0]      digit;
  logic [19:0]     acc_next;
  logic [15:0]     acc_sat;
  res_t            pix_res, st_res;

  // header check with the current field in the accumulator, later fields zero
  function automatic logic hdr_ok(phase_e ph, logic [15:0] acc, logic [15:0] wid,
                                  logic [15:0] hei);
    logic [15:0] w;
    logic [15:0] h;
    logic [15:0] m;
    w = 16'd0;
    h = 16'd0;
    m = 16'd0;
    case (ph) inside
      PH_WS_W, PH_NUM_W: begin
        w = acc;
      end
      PH_WS_H, PH_NUM_H: begin
        w = wid;
        h = acc;
      end
      default: begin
        w = wid;
        h = hei;
        m = acc;
      end
    endcase
    return (w == 16'(IMAGE_WIDTH)) && (h == 16'(IMAGE_HEIGHT)) && (m == MaxVal);
  endfunction

  // character classes and saturating decimal accumulate
  assign is_digit = (byte_i >= ChZero) && (byte_i <= ChNine);
  assign is_blank = (byte_i == ChSpace) || (byte_i == ChTab) ||
                    (byte_i == ChCr) || (byte_i == ChLf);
  assign digit    = 4'(byte_i - ChZero);
  assign acc_next = ({4'd0, acc_q} << 3) + ({4'd0, acc_q} << 1) + {16'd0, digit};
  assign acc_sat  = (acc_next[19:16] != 4'd0) ? 16'hFFFF : acc_next[15:0];

  // next state and results for one byte
  always_comb begin
    phase_d      = phase_q;
    in_comment_d = in_comment_q;
    acc_d        = acc_q;
    wid_d        = wid_q;
    hei_d        = hei_q;
    slot_d       = slot_q;
    pix_d        = pix_q;
    red_d        = red_q;
    grn_d        = grn_q;
    emit_pix     = 1'b0;
    emit_st      = 1'b0;
    st_code      = ST_OK;

    unique case (phase_q) inside
      PH_MAGIC_P: begin
        if (byte_i == ChP) begin
          phase_d = PH_MAGIC_6;
        end else begin
          emit_st = 1'b1;
          st_code = ST_MAGIC;
          phase_d = PH_DONE;
        end
      end
      PH_MAGIC_6: begin
        if (byte_i == ChSix) begin
          phase_d = PH_WS_W;
          acc_d   = 16'd0;
        end else begin
          emit_st = 1'b1;
          st_code = ST_MAGIC;
          phase_d = PH_DONE;
        end
      end
      PH_PAYLOAD: begin
        case (slot_q)
          2'd0: begin
            red_d  = byte_i;
            slot_d = 2'd1;
          end
          2'd1: begin
            grn_d  = byte_i;
            slot_d = 2'd2;
          end
          default: begin
            emit_pix = 1'b1;
            slot_d   = 2'd0;
            if (pix_q == PixLast) begin
              emit_st = 1'b1;
              st_code = ST_OK;
              phase_d = PH_DONE;
            end else begin
              pix_d = pix_q + PixW'(1);
            end
          end
        endcase
      end
      PH_DONE: begin
        phase_d = PH_DONE;
      end
      PH_WS_W, PH_NUM_W, PH_WS_H, PH_NUM_H, PH_WS_M, PH_NUM_M: begin
        if (in_comment_q) begin
          if (byte_i == ChLf) begin
            in_comment_d = 1'b0;
          end
        end else if (phase_q == PH_WS_W || phase_q == PH_WS_H || phase_q == PH_WS_M) begin
          if (byte_i == ChHash) begin
            in_comment_d = 1'b1;
          end else if (is_digit) begin
            acc_d = {12'd0, digit};
            case (phase_q)
              PH_WS_W: phase_d = PH_NUM_W;
              PH_WS_H: phase_d = PH_NUM_H;
              default: phase_d = PH_NUM_M;
            endcase
          end else if (!is_blank) begin
            if (hdr_ok(phase_q, acc_q, wid_q, hei_q)) begin
              phase_d = PH_PAYLOAD;
              slot_d  = 2'd0;
              pix_d   = '0;
            end else begin
              emit_st = 1'b1;
              st_code = ST_HEADER;
              phase_d = PH_DONE;
            end
          end
        end else if (is_digit) begin
          acc_d = acc_sat;
        end else if (phase_q != PH_NUM_M && (is_blank || byte_i == ChHash)) begin
          // field complete, move on to the gap before the next one
          if (phase_q == PH_NUM_W) begin
            wid_d   = acc_q;
            phase_d = PH_WS_H;
          end else begin
            hei_d   = acc_q;
            phase_d = PH_WS_M;
          end
          acc_d        = 16'd0;
          in_comment_d = (byte_i == ChHash);
        end else begin
          // separator or stray character ends the header
          if (hdr_ok(phase_q, acc_q, wid_q, hei_q)) begin
            phase_d = PH_PAYLOAD;
            slot_d  = 2'd0;
            pix_d   = '0;
          end else begin
            emit_st = 1'b1;
            st_code = ST_HEADER;
            phase_d = PH_DONE;
          end
        end
      end
      default: begin
        phase_d = PH_DONE;
      end
    endcase

    // end of file closes the run if nothing else did
    if (eof_i && !emit_st && phase_q != PH_DONE) begin
      emit_st = 1'b1;
      if (phase_d == PH_MAGIC_P || phase_d == PH_MAGIC_6) begin
        st_code = ST_MAGIC;
      end else if (phase_d == PH_PAYLOAD) begin
        st_code = ST_SHORT;
      end else if (hdr_ok(phase_d, acc_d, wid_d, hei_d)) begin
        st_code = ST_SHORT;
      end else begin
        st_code = ST_HEADER;
      end
      phase_d = PH_DONE;
    end
  end

  // result words
  always_comb begin
    pix_res.kind        = KIND_PIXEL;
    pix_res.pixel_index = 8'(pix_q);
    pix_res.red         = red_q;
    pix_res.green       = grn_q;
    pix_res.blue        = byte_i;
    pix_res.status      = ST_OK;
    pix_res.run_end     = !emit_st;

    st_res.kind        = KIND_STATUS;
    st_res.pixel_index = 8'd0;
    st_res.red         = 8'd0;
    st_res.green       = 8'd0;
    st_res.blue        = 8'd0;
    st_res.status      = st_code;
    st_res.run_end     = 1'b1;

    res_a_o    = emit_pix ? pix_res : st_res;
    res_b_o    = st_res;
    push_cnt_o = fire_i ? ({1'b0, emit_pix} + {1'b0, emit_st}) : 2'd0;
  end

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_MAGIC_P;
      in_comment_q <= 1'b0;
      acc_q        <= 16'd0;
      wid_q        <= 16'd0;
      hei_q        <= 16'd0;
      slot_q       <= 2'd0;
      pix_q        <= '0;
      red_q        <= 8'd0;
      grn_q        <= 8'd0;
    end else if (fire_i) begin
      phase_q      <= phase_d;
      in_comment_q <= in_comment_d;
      acc_q        <= acc_d;
      wid_q        <= wid_d;
      hei_q        <= hei_d;
      slot_q       <= slot_d;
      pix_q        <= pix_d;
      red_q        <= red_d;
      grn_q        <= grn_d;
    end
  end

endmodule

### rtl/core/ppmp6_res_fifo.sv
// small result queue taking up to two words a cycle, one word out
module ppmp6_res_fifo import ppmp6_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [1:0] push_cnt_i,
  input  res_t       push_a_i,
  input  res_t       push_b_i,
  output logic       room_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output res_t       out_word_o
);

  res_t                mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_q, rd_q;
  logic [FifoCntW-1:0] cnt_q;
  logic                pop;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (cnt_q != '0);
  assign out_word_o  = mem_q[rd_q];
  // room for a pixel and a status word together
  assign room_o      = (cnt_q <= FifoCntW'(FifoDepth - 2));

  // storage writes
  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      mem_q[wr_q] <= push_a_i;
    end
    if (push_cnt_i == 2'd2) begin
      mem_q[wr_q + FifoPtrW'(1)] <= push_b_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + FifoPtrW'(push_cnt_i);
      rd_q  <= rd_q + FifoPtrW'(pop);
      cnt_q <= cnt_q + FifoCntW'(push_cnt_i) - FifoCntW'(pop);
    end
  end

endmodule

### rtl/core/ppm_p6_sprite_parser_core.sv
// p6 image stream parser: input register, parser and result queue
// results: a byte's words are pushed into the result queue as it leaves the input register
// throughput: one byte per cycle while the result queue has room; the parser state register is the only loop
// a byte giving a pixel and the final status occupies two queue slots
// reset: asynchronous active low; waits for the first magic byte, queue empty
// after the status word every byte is accepted and dropped until reset
module ppm_p6_sprite_parser_core import ppmp6_pkg::*; #(
  parameter int unsigned IMAGE_WIDTH  = ImageWidthDef,
  parameter int unsigned IMAGE_HEIGHT = ImageHeightDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       end_of_file_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       kind_o,
  output logic [7:0] pixel_index_o,
  output logic [7:0] red_o,
  output logic [7:0] green_o,
  output logic [7:0] blue_o,
  output logic [1:0] status_o,
  output logic       run_end_o
);

  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       in_eof_q;
  logic       room;
  logic       fire;
  logic [1:0] push_cnt;
  res_t       res_a, res_b, out_word;

  // input word register
  assign fire       = in_vld_q && room;
  assign in_ready_o = !in_vld_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q <= data_byte_i;
      in_eof_q  <= end_of_file_i;
    end
  end

  ppmp6_parser #(
    .IMAGE_WIDTH  (IMAGE_WIDTH),
    .IMAGE_HEIGHT (IMAGE_HEIGHT)
  ) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .byte_i     (in_byte_q),
    .eof_i      (in_eof_q),
    .push_cnt_o (push_cnt),
    .res_a_o    (res_a),
    .res_b_o    (res_b)
  );

  ppmp6_res_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_cnt_i  (push_cnt),
    .push_a_i    (res_a),
    .push_b_i    (res_b),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word)
  );

  // result fields
  assign kind_o        = out_word.kind;
  assign pixel_index_o = out_word.pixel_index;
  assign red_o         = out_word.red;
  assign green_o       = out_word.green;
  assign blue_o        = out_word.blue;
  assign status_o      = out_word.status;
  assign run_end_o     = out_word.run_end;

endmodule

### sim/tb_top.sv
// self-checking testbench for the p6 sprite parser core
`timescale 1ns / 1ps

module tb_top;
  import ppmp6_pkg::*;

  localparam int unsigned PixelCount   = ImageWidthDef * ImageHeightDef;
  localparam int unsigned PayloadBytes = PixelCount * 3;

  // clock, reset and block ports
  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       in_valid      = 1'b0;
  logic       in_ready;
  logic [7:0] data_byte     = 8'h00;
  logic       end_of_file   = 1'b0;
  logic       out_valid;
  logic       out_ready     = 1'b0;
  logic       kind;
  logic [7:0] pixel_index;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [1:0] status;
  logic       run_end;

  // run control
  logic calm   = 1'b0;
  int   errors = 0;

  // expected words, oldest first
  res_t expected_words[$];
  res_t step_words[$];

  // shadow of the parser state
  phase_e      hdr_phase  = PH_MAGIC_P;
  logic        in_remark  = 1'b0;
  int unsigned num_acc    = 0;
  int unsigned width_got  = 0;
  int unsigned height_got = 0;
  int unsigned byte_count = 0;
  logic [7:0]  red_hold   = 8'h00;
  logic [7:0]  green_hold = 8'h00;
  logic        finished   = 1'b0;

  ppm_p6_sprite_parser_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .data_byte_i   (data_byte),
    .end_of_file_i (end_of_file),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .kind_o        (kind),
    .pixel_index_o (pixel_index),
    .red_o         (red),
    .green_o       (green),
    .blue_o        (blue),
    .status_o      (status),
    .run_end_o     (run_end)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // run limit
  initial begin
    #3_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic logic is_blank(input logic [7:0] c);
    return c == ChSpace || c == ChTab || c == ChCr || c == ChLf;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= ChZero && c <= ChNine;
  endfunction

  // header check: current field from the accumulator, later fields zero
  function automatic logic header_fits();
    int unsigned w;
    int unsigned h;
    int unsigned m;
    w = 0;
    h = 0;
    m = 0;
    if (hdr_phase == PH_WS_W || hdr_phase == PH_NUM_W) begin
      w = num_acc;
    end else if (hdr_phase == PH_WS_H || hdr_phase == PH_NUM_H) begin
      w = width_got;
      h = num_acc;
    end else begin
      w = width_got;
      h = height_got;
      m = num_acc;
    end
    return w == ImageWidthDef && h == ImageHeightDef && m == MaxVal;
  endfunction

  function automatic void give_status(input status_e st);
    step_words.push_back('{KIND_STATUS, 8'd0, 8'd0, 8'd0, 8'd0, st, 1'b0});
    finished  = 1'b1;
    hdr_phase = PH_DONE;
  endfunction

  function automatic void add_digit(input logic [7:0] c);
    int unsigned v;
    v = num_acc * 10 + (c - ChZero);
    num_acc = (v > 65535) ? 65535 : v;
  endfunction

  function automatic void end_header();
    if (header_fits()) begin
      hdr_phase  = PH_PAYLOAD;
      byte_count = 0;
    end else begin
      give_status(ST_HEADER);
    end
  endfunction

  // works out the words one accepted byte gives and queues them
  function automatic void parse_byte(input logic [7:0] c, input logic eof);
    res_t w;
    step_words.delete();
    if (finished || hdr_phase == PH_DONE) return;

    if (hdr_phase == PH_MAGIC_P) begin
      if (c == ChP) hdr_phase = PH_MAGIC_6;
      else give_status(ST_MAGIC);
    end else if (hdr_phase == PH_MAGIC_6) begin
      if (c == ChSix) begin
        hdr_phase = PH_WS_W;
        num_acc   = 0;
      end else begin
        give_status(ST_MAGIC);
      end
    end else if (hdr_phase == PH_PAYLOAD) begin
      case (byte_count % 3)
        0: red_hold = c;
        1: green_hold = c;
        default: begin
          w = '{KIND_PIXEL, 8'(byte_count / 3), red_hold, green_hold, c, ST_OK, 1'b0};
          step_words.push_back(w);
        end
      endcase
      byte_count++;
      if (byte_count >= PayloadBytes) give_status(ST_OK);
    end else if (in_remark) begin
      if (c == ChLf) in_remark = 1'b0;
    end else if (hdr_phase == PH_WS_W || hdr_phase == PH_WS_H || hdr_phase == PH_WS_M) begin
      if (c == ChHash) begin
        in_remark = 1'b1;
      end else if (is_digit(c)) begin
        hdr_phase = phase_e'(hdr_phase + 4'd1);
        num_acc   = 0;
        add_digit(c);
      end else if (!is_blank(c)) begin
        end_header();
      end
    end else if (is_digit(c)) begin
      add_digit(c);
    end else if (hdr_phase == PH_NUM_M) begin
      end_header();
    end else if (is_blank(c) || c == ChHash) begin
      if (hdr_phase == PH_NUM_W) width_got = num_acc;
      else height_got = num_acc;
      num_acc   = 0;
      hdr_phase = phase_e'(hdr_phase + 4'd1);
      in_remark = (c == ChHash);
    end else begin
      end_header();
    end

    // end of file before a status was given
    if (eof && !finished) begin
      if (hdr_phase == PH_MAGIC_P || hdr_phase == PH_MAGIC_6) give_status(ST_MAGIC);
      else if (hdr_phase == PH_PAYLOAD) give_status(ST_SHORT);
      else give_status(header_fits() ? ST_SHORT : ST_HEADER);
    end

    if (step_words.size() != 0) begin
      w = step_words.pop_back();
      w.run_end = 1'b1;
      step_words.push_back(w);
    end
    while (step_words.size() != 0) expected_words.push_back(step_words.pop_front());
  endfunction

  // result side stalls
  always @(posedge clk_i) begin
    out_ready <= calm || ($urandom_range(99) >= 31);
  end

  function automatic void compare_field(input string name, input int unsigned exp_v,
                                        input int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: mismatch on %s, expected %0d, actual %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endfunction

  // checks each accepted result word against the oldest expectation
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        $display({"%0t: unexpected word, expected none, actual kind %0d idx %0d",
                  " rgb %0d %0d %0d st %0d end %0d"},
                 $time, kind, pixel_index, red, green, blue, status, run_end);
        errors++;
      end else begin
        want = expected_words.pop_front();
        compare_field("kind", want.kind, kind);
        compare_field("pixel_index", want.pixel_index, pixel_index);
        compare_field("red", want.red, red);
        compare_field("green", want.green, green);
        compare_field("blue", want.blue, blue);
        compare_field("status", want.status, status);
        compare_field("run_end", want.run_end, run_end);
      end
    end
  end

  // sends one byte; called and returns at a rising edge
  task automatic send_byte(input logic [7:0] b, input logic last);
    while (!calm && $urandom_range(99) < 31) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid    <= 1'b1;
    data_byte   <= b;
    end_of_file <= last;
    parse_byte(b, last);
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
  endtask

  task automatic send_remark(input int unsigned len);
    logic [7:0] b;
    send_byte(ChHash, 1'b0);
    repeat (len) begin
      do b = 8'($urandom_range(255)); while (b == ChLf);
      send_byte(b, 1'b0);
    end
    send_byte(ChLf, 1'b0);
  endtask

  task automatic test_magic();
    send_byte(ChP, 1'b0);
    send_byte(ChSix, 1'b0);
  endtask

  // long run of blanks and comments with random content before the width
  task automatic test_header_filler();
    int unsigned sent;
    int unsigned len;
    logic [7:0] blanks[4];
    blanks = '{ChSpace, ChTab, ChCr, ChLf};
    sent = 0;
    while (sent < 1100) begin
      calm = (sent >= 250 && sent < 550);
      if ($urandom_range(9) < 6) begin
        send_byte(blanks[$urandom_range(3)], 1'b0);
        sent++;
      end else begin
        len = $urandom_range(30);
        send_remark(len);
        sent += len + 2;
      end
    end
    calm = 1'b0;
  endtask

  // leading zeros, a comment closing a field, carriage return, tab and space blanks, separator
  task automatic test_header_fields();
    logic [7:0] sep;
    send_byte(ChZero, 1'b0);
    send_byte(ChZero, 1'b0);
    send_byte(8'h31, 1'b0);
    send_byte(8'h36, 1'b0);
    send_byte(ChHash, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(ChLf, 1'b0);
    send_byte(ChCr, 1'b0);
    send_byte(8'h31, 1'b0);
    send_byte(8'h36, 1'b0);
    send_byte(ChTab, 1'b0);
    send_byte(ChSpace, 1'b0);
    send_byte(ChZero, 1'b0);
    send_byte(ChZero, 1'b0);
    send_byte(8'h32, 1'b0);
    send_byte(8'h35, 1'b0);
    send_byte(8'h35, 1'b0);
    do sep = 8'($urandom_range(255)); while (is_digit(sep));
    send_byte(sep, 1'b0);
  endtask

  // pixel data, full or cut short by end of file, with one drain pause
  task automatic test_payload();
    int unsigned stop_at;
    logic [7:0] b;
    stop_at = ($urandom_range(3) == 0) ? $urandom_range(600, PayloadBytes - 1)
                                       : PayloadBytes;
    for (int unsigned i = 0; i < stop_at; i++) begin
      calm = (i >= 100 && i < 350);
      if (i == 400) begin
        in_valid <= 1'b0;
        @(posedge clk_i);
        while (expected_words.size() != 0) @(posedge clk_i);
      end
      case ($urandom_range(7))
        0: b = 8'h00;
        1: b = 8'hFF;
        default: b = 8'($urandom_range(255));
      endcase
      send_byte(b, i == stop_at - 1);
    end
    calm = 1'b0;
  endtask

  // bytes after the status word must give nothing
  task automatic test_after_status();
    repeat (40) send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_magic();
    test_header_filler();
    test_header_fields();
    test_payload();
    test_after_status();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
